### design/rvcie_pkg.sv
// rvcie_pkg.sv: opcodes, selector codes and encoding helpers for the rvc expander
`timescale 1ns / 1ps

package rvcie_pkg;

    // base opcodes of the 32-bit forms produced
    localparam logic [6:0] OPC_OP_IMM   = 7'b0010011;
    localparam logic [6:0] OPC_JAL      = 7'b1101111;
    localparam logic [6:0] OPC_OP       = 7'b0110011;
    localparam logic [6:0] OPC_BRANCH   = 7'b1100011;
    localparam logic [6:0] OPC_STORE    = 7'b0100011;
    localparam logic [6:0] OPC_LOAD     = 7'b0000011;
    localparam logic [6:0] OPC_LOAD_FP  = 7'b0000111;
    localparam logic [6:0] OPC_STORE_FP = 7'b0100111;
    localparam logic [6:0] OPC_JALR     = 7'b1100111;
    localparam logic [6:0] OPC_SYSTEM   = 7'b1110011;
    localparam logic [6:0] OPC_LUI      = 7'b0110111;

    // marks srai in the i-type immediate
    localparam logic [11:0] SRAI_MARK = 12'h400;

    // funct7 of sub
    localparam logic [6:0] F7_SUB  = 7'b0100000;
    localparam logic [6:0] F7_NONE = 7'b0000000;

    // funct3 values of the expanded instructions
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_W    = 3'd2;
    localparam logic [2:0] F3_D    = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    // quadrant codes in bits 1:0
    localparam logic [1:0] QUAD_0    = 2'b00;
    localparam logic [1:0] QUAD_1    = 2'b01;
    localparam logic [1:0] QUAD_2    = 2'b10;
    localparam logic [1:0] QUAD_FULL = 2'b11;

    // quadrant 0 funct3
    localparam logic [2:0] C0_ADDI4SPN = 3'd0;
    localparam logic [2:0] C0_FLD      = 3'd1;
    localparam logic [2:0] C0_LW       = 3'd2;
    localparam logic [2:0] C0_FLW      = 3'd3;
    localparam logic [2:0] C0_RSVD     = 3'd4;
    localparam logic [2:0] C0_FSD      = 3'd5;
    localparam logic [2:0] C0_SW       = 3'd6;
    localparam logic [2:0] C0_FSW      = 3'd7;

    // quadrant 1 funct3
    localparam logic [2:0] C1_ADDI     = 3'd0;
    localparam logic [2:0] C1_JAL      = 3'd1;
    localparam logic [2:0] C1_LI       = 3'd2;
    localparam logic [2:0] C1_LUI      = 3'd3;
    localparam logic [2:0] C1_ALU      = 3'd4;
    localparam logic [2:0] C1_J        = 3'd5;
    localparam logic [2:0] C1_BEQZ     = 3'd6;
    localparam logic [2:0] C1_BNEZ     = 3'd7;

    // quadrant 1 alu group, bits 11:10 and 6:5
    localparam logic [1:0] ALU_SRLI = 2'd0;
    localparam logic [1:0] ALU_SRAI = 2'd1;
    localparam logic [1:0] ALU_ANDI = 2'd2;
    localparam logic [1:0] ALU_REG  = 2'd3;
    localparam logic [1:0] REG_SUB  = 2'd0;
    localparam logic [1:0] REG_XOR  = 2'd1;
    localparam logic [1:0] REG_OR   = 2'd2;
    localparam logic [1:0] REG_AND  = 2'd3;

    // quadrant 2 funct3
    localparam logic [2:0] C2_SLLI     = 3'd0;
    localparam logic [2:0] C2_FLDSP    = 3'd1;
    localparam logic [2:0] C2_LWSP     = 3'd2;
    localparam logic [2:0] C2_FLWSP    = 3'd3;
    localparam logic [2:0] C2_JR_ADD   = 3'd4;
    localparam logic [2:0] C2_FSDSP    = 3'd5;
    localparam logic [2:0] C2_SWSP     = 3'd6;
    localparam logic [2:0] C2_FSWSP    = 3'd7;

    // fixed registers
    localparam logic [4:0] REG_X0 = 5'd0;
    localparam logic [4:0] REG_RA = 5'd1;
    localparam logic [4:0] REG_SP = 5'd2;

    // result of one expansion
    typedef struct packed {
        logic [31:0] expanded;
        logic        was_compressed;
        logic        illegal;
    } t_exp_result;

    // i-type
    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    // s-type
    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [6:0] op);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
    endfunction

    // r-type
    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    // b-type, 13-bit byte offset
    function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [6:0] op);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], op};
    endfunction

    // j-type, 21-bit byte offset
    function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd,
                                          input logic [6:0] op);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, op};
    endfunction

endpackage

### design/rvc_instruction_expander_unit.sv
// rvc_instruction_expander_unit.sv: top level of the compressed instruction expander
`timescale 1ns / 1ps

// Expands RV32 compressed instructions (I/F/D subset) into their 32-bit form; full-length
// words pass through untouched. The unit is a two-register pipeline: the fetched word is
// captured in an input register, expanded by one level of decode logic, and captured in a
// result register. One transaction can be accepted every cycle; the input register and the
// result register each hold their item while downstream stalls, so throughput drops only
// when i_stall is high. The reserved quadrant-0 slot returns zero with o_illegal set. There
// is no configuration and no state beyond the pipeline.

module rvc_instruction_expander_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instruction,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_expanded,
    output logic        o_was_compressed,
    output logic        o_illegal
);
    import rvcie_pkg::*;

    logic        r_in_valid;
    logic [31:0] r_in_instr;
    logic        r_out_valid;
    t_exp_result r_out;
    t_exp_result exp_result;
    logic        out_hold;
    logic        in_hold;

    // stage advance control
    assign out_hold = r_out_valid && i_stall;
    assign in_hold  = r_in_valid && out_hold;
    assign o_stall  = in_hold;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!in_hold) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!in_hold && i_valid) begin
            r_in_instr <= i_instruction;
        end
    end

    // decode
    rvcie_expander u_expander (
        .i_instruction (r_in_instr),
        .o_result      (exp_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_hold) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_hold && r_in_valid) begin
            r_out <= exp_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_expanded       = r_out.expanded;
    assign o_was_compressed = r_out.was_compressed;
    assign o_illegal        = r_out.illegal;

    // an illegal result is a compressed word expanded to zero
    a_illegal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_illegal) |-> (o_was_compressed && o_expanded == 32'd0))
        else $error("illegal result with nonzero expansion");

    // every valid result is a full-length encoding unless illegal
    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_illegal) |-> (o_expanded[1:0] == QUAD_FULL))
        else $error("expanded word is not a full-length encoding");

    // input side stalls only when both registers are occupied and output is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a full pipeline");

    // an accepted transaction reaches the input register
    a_accept_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_in_valid && r_in_instr == $past(i_instruction)))
        else $error("accepted transaction not captured");

endmodule

### design/rvcie_expander.sv
// rvcie_expander.sv: combinational expansion of one fetched word
`timescale 1ns / 1ps

module rvcie_expander (
    input  logic [31:0]                 i_instruction,
    output rvcie_pkg::t_exp_result      o_result
);
    import rvcie_pkg::*;

    logic [15:0] c;
    logic [1:0]  quad;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [4:0]  rdp;
    logic [4:0]  rs2p;
    logic [5:0]  ci_u;
    logic [11:0] ci_s;
    logic [20:0] imm_j;
    logic [12:0] imm_b;
    logic [6:0]  off_w;
    logic [7:0]  off_d;
    logic [9:0]  off_4spn;
    logic [11:0] off_16sp;
    logic [8:0]  off_ldsp;
    logic [7:0]  off_lwsp;
    logic [8:0]  off_sdsp;
    logic [7:0]  off_swsp;
    logic [31:0] exp16;
    logic        bad;

    // field extraction
    assign c     = i_instruction[15:0];
    assign quad  = c[1:0];
    assign f3    = c[15:13];
    assign rd    = c[11:7];
    assign rs2   = c[6:2];
    assign rdp   = {2'b01, c[9:7]};
    assign rs2p  = {2'b01, c[4:2]};
    assign ci_u  = {c[12], c[6:2]};
    assign ci_s  = {{6{c[12]}}, c[12], c[6:2]};

    // immediates
    assign imm_j    = {{10{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
    assign imm_b    = {{5{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
    assign off_w    = {c[5], c[12:10], c[6], 2'b00};
    assign off_d    = {c[6:5], c[12:10], 3'b000};
    assign off_4spn = {c[10:7], c[12:11], c[5], c[6], 2'b00};
    assign off_16sp = {{3{c[12]}}, c[4:3], c[5], c[2], c[6], 4'b0000};
    assign off_ldsp = {c[4:2], c[12], c[6:5], 3'b000};
    assign off_lwsp = {c[3:2], c[12], c[6:4], 2'b00};
    assign off_sdsp = {c[9:7], c[12:10], 3'b000};
    assign off_swsp = {c[8:7], c[12:9], 2'b00};

    // expansion table
    always_comb begin
        exp16 = '0;
        bad   = 1'b0;
        case (quad)
            QUAD_0: begin
                case (f3)
                    C0_ADDI4SPN: exp16 = enc_i({2'b00, off_4spn}, REG_SP, F3_ADD, rs2p,
                                               OPC_OP_IMM);
                    C0_FLD:  exp16 = enc_i({4'b0000, off_d}, rdp, F3_D, rs2p, OPC_LOAD_FP);
                    C0_LW:   exp16 = enc_i({5'b00000, off_w}, rdp, F3_W, rs2p, OPC_LOAD);
                    C0_FLW:  exp16 = enc_i({5'b00000, off_w}, rdp, F3_W, rs2p, OPC_LOAD_FP);
                    C0_RSVD: begin
                        exp16 = '0;
                        bad   = 1'b1;
                    end
                    C0_FSD:  exp16 = enc_s({4'b0000, off_d}, rs2p, rdp, F3_D, OPC_STORE_FP);
                    C0_SW:   exp16 = enc_s({5'b00000, off_w}, rs2p, rdp, F3_W, OPC_STORE);
                    C0_FSW:  exp16 = enc_s({5'b00000, off_w}, rs2p, rdp, F3_W, OPC_STORE_FP);
                    default: exp16 = '0;
                endcase
            end
            QUAD_1: begin
                case (f3)
                    C1_ADDI: exp16 = enc_i(ci_s, rd, F3_ADD, rd, OPC_OP_IMM);
                    C1_JAL:  exp16 = enc_j(imm_j, REG_RA, OPC_JAL);
                    C1_LI:   exp16 = enc_i(ci_s, REG_X0, F3_ADD, rd, OPC_OP_IMM);
                    C1_LUI: begin
                        // rd of sp selects addi16sp
                        if (rd == REG_SP) begin
                            exp16 = enc_i(off_16sp, REG_SP, F3_ADD, REG_SP, OPC_OP_IMM);
                        end else begin
                            exp16 = {{14{c[12]}}, c[12], c[6:2], rd, OPC_LUI};
                        end
                    end
                    C1_ALU: begin
                        case (c[11:10])
                            ALU_SRLI: exp16 = enc_i({6'b000000, ci_u}, rdp, F3_SR, rdp,
                                                    OPC_OP_IMM);
                            ALU_SRAI: exp16 = enc_i({6'b000000, ci_u} | SRAI_MARK, rdp, F3_SR,
                                                    rdp, OPC_OP_IMM);
                            ALU_ANDI: exp16 = enc_i(ci_s, rdp, F3_AND, rdp, OPC_OP_IMM);
                            ALU_REG: begin
                                case (c[6:5])
                                    REG_SUB: exp16 = enc_r(F7_SUB, rs2p, rdp, F3_ADD, rdp,
                                                           OPC_OP);
                                    REG_XOR: exp16 = enc_r(F7_NONE, rs2p, rdp, F3_XOR, rdp,
                                                           OPC_OP);
                                    REG_OR:  exp16 = enc_r(F7_NONE, rs2p, rdp, F3_OR, rdp,
                                                           OPC_OP);
                                    REG_AND: exp16 = enc_r(F7_NONE, rs2p, rdp, F3_AND, rdp,
                                                           OPC_OP);
                                    default: exp16 = '0;
                                endcase
                            end
                            default: exp16 = '0;
                        endcase
                    end
                    C1_J:    exp16 = enc_j(imm_j, REG_X0, OPC_JAL);
                    C1_BEQZ: exp16 = enc_b(imm_b, REG_X0, rdp, F3_BEQ, OPC_BRANCH);
                    C1_BNEZ: exp16 = enc_b(imm_b, REG_X0, rdp, F3_BNE, OPC_BRANCH);
                    default: exp16 = '0;
                endcase
            end
            QUAD_2: begin
                case (f3)
                    C2_SLLI:  exp16 = enc_i({6'b000000, ci_u}, rd, F3_SLL, rd, OPC_OP_IMM);
                    C2_FLDSP: exp16 = enc_i({3'b000, off_ldsp}, REG_SP, F3_D, rd, OPC_LOAD_FP);
                    C2_LWSP:  exp16 = enc_i({4'b0000, off_lwsp}, REG_SP, F3_W, rd, OPC_LOAD);
                    C2_FLWSP: exp16 = enc_i({4'b0000, off_lwsp}, REG_SP, F3_W, rd,
                                            OPC_LOAD_FP);
                    C2_JR_ADD: begin
                        // jr / mv / ebreak / jalr / add
                        if (!c[12]) begin
                            if (rs2 != REG_X0) begin
                                exp16 = enc_r(F7_NONE, rs2, REG_X0, F3_ADD, rd, OPC_OP);
                            end else begin
                                exp16 = enc_i(12'd0, rd, F3_ADD, REG_X0, OPC_JALR);
                            end
                        end else if (rs2 != REG_X0) begin
                            exp16 = enc_r(F7_NONE, rs2, rd, F3_ADD, rd, OPC_OP);
                        end else if (rd == REG_X0) begin
                            exp16 = enc_i(12'd1, REG_X0, F3_ADD, REG_X0, OPC_SYSTEM);
                        end else begin
                            exp16 = enc_i(12'd0, rd, F3_ADD, REG_RA, OPC_JALR);
                        end
                    end
                    C2_FSDSP: exp16 = enc_s({3'b000, off_sdsp}, rs2, REG_SP, F3_D,
                                            OPC_STORE_FP);
                    C2_SWSP:  exp16 = enc_s({4'b0000, off_swsp}, rs2, REG_SP, F3_W, OPC_STORE);
                    C2_FSWSP: exp16 = enc_s({4'b0000, off_swsp}, rs2, REG_SP, F3_W,
                                            OPC_STORE_FP);
                    default:  exp16 = '0;
                endcase
            end
            default: begin
                exp16 = '0;
                bad   = 1'b0;
            end
        endcase
    end

    // full-length words pass through
    always_comb begin
        if (quad == QUAD_FULL) begin
            o_result.expanded       = i_instruction;
            o_result.was_compressed = 1'b0;
            o_result.illegal        = 1'b0;
        end else begin
            o_result.expanded       = exp16;
            o_result.was_compressed = 1'b1;
            o_result.illegal        = bad;
        end
    end

endmodule

### dv/tb_rvc_instruction_expander_unit.sv
// tb_rvc_instruction_expander_unit.sv: self-checking testbench for the rvc instruction expander
`timescale 1ns / 1ps

module tb_rvc_instruction_expander_unit;
    import rvcie_pkg::*;

    localparam int          RANDOM_ITEMS    = 1600;
    localparam int          IDLE_LIMIT      = 5000;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          HOLD_AFTER      = 400;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          REPORT_LIMIT    = 10;
    localparam logic [11:0] EBREAK_IMM      = 12'd1;
    localparam logic [2:0]  F3_PRIV         = 3'd0;

    // one per form of quadrants 0, 1 and 2, the reserved slot, addi16sp, jalr and ebreak too
    localparam logic [15:0] DIRECTED_CODES [0:34] = '{
        16'h1FFC, 16'h3FFC, 16'h5FFC, 16'h7FFC, 16'h9FFC, 16'hBFFC, 16'hDFFC, 16'hFFFC,
        16'h1FFD, 16'h3FFD, 16'h5FFD, 16'h717D, 16'h72FD, 16'h8001, 16'h97FD, 16'h887D,
        16'h8C01, 16'h8C21, 16'h8C41, 16'h9C7D, 16'hBFFD, 16'hDFFD, 16'hFFFD,
        16'h1FFE, 16'h3FFE, 16'h5FFE, 16'h7FFE, 16'h8002, 16'h8FFE, 16'h9F82, 16'h9002,
        16'h9FFE, 16'hBFFE, 16'hDFFE, 16'hFFFE
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_instruction;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_expanded;
    logic        o_was_compressed;
    logic        o_illegal;

    int unsigned idle_cycles = 0;

    // expected expansions in order of acceptance, checked against each result
    class expansion_scoreboard;
        t_exp_result pending_expansions[$];
        logic [31:0] pending_words[$];
        int unsigned mismatch_count = 0;
        int unsigned accepted_count = 0;

        // rewrite one fetched word as the 32-bit instruction it stands for
        function t_exp_result expand_word(logic [31:0] word);
            t_exp_result res;
            logic [15:0] c;
            logic [4:0]  rd, rs2, rdp, rs2p;
            logic [5:0]  ci_u;
            logic [11:0] ci_s, s_imm;
            logic [6:0]  w_off;
            logic [7:0]  d_off;
            logic [9:0]  jump_mid;
            c                  = word[15:0];
            res.expanded       = word;
            res.was_compressed = 1'b0;
            res.illegal        = 1'b0;
            if (word[1:0] == QUAD_FULL) begin
                return res;
            end
            res.was_compressed = 1'b1;
            rd       = c[11:7];
            rs2      = c[6:2];
            rdp      = {2'b01, c[9:7]};
            rs2p     = {2'b01, c[4:2]};
            ci_u     = {c[12], c[6:2]};
            ci_s     = {{6{c[12]}}, ci_u};
            w_off    = {c[5], c[12:10], c[6], 2'b00};
            d_off    = {c[6:5], c[12:10], 3'b000};
            jump_mid = {c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3]};
            case (c[1:0])
                QUAD_0: begin
                    case (c[15:13])
                        C0_ADDI4SPN: res.expanded = {2'b00, c[10:7], c[12:11], c[5], c[6], 2'b00,
                                                     REG_SP, F3_ADD, rs2p, OPC_OP_IMM};
                        C0_FLD: res.expanded = {4'b0, d_off, rdp, F3_D, rs2p, OPC_LOAD_FP};
                        C0_LW:  res.expanded = {5'b0, w_off, rdp, F3_W, rs2p, OPC_LOAD};
                        C0_FLW: res.expanded = {5'b0, w_off, rdp, F3_W, rs2p, OPC_LOAD_FP};
                        C0_RSVD: begin
                            res.expanded = '0;
                            res.illegal  = 1'b1;
                        end
                        C0_FSD: begin
                            s_imm        = {4'b0, d_off};
                            res.expanded = {s_imm[11:5], rs2p, rdp, F3_D, s_imm[4:0], OPC_STORE_FP};
                        end
                        C0_SW: begin
                            s_imm        = {5'b0, w_off};
                            res.expanded = {s_imm[11:5], rs2p, rdp, F3_W, s_imm[4:0], OPC_STORE};
                        end
                        C0_FSW: begin
                            s_imm        = {5'b0, w_off};
                            res.expanded = {s_imm[11:5], rs2p, rdp, F3_W, s_imm[4:0], OPC_STORE_FP};
                        end
                    endcase
                end
                QUAD_1: begin
                    case (c[15:13])
                        C1_ADDI: res.expanded = {ci_s, rd, F3_ADD, rd, OPC_OP_IMM};
                        C1_JAL:  res.expanded = {c[12], jump_mid, c[12], {8{c[12]}}, REG_RA, OPC_JAL};
                        C1_LI:   res.expanded = {ci_s, REG_X0, F3_ADD, rd, OPC_OP_IMM};
                        C1_LUI: begin
                            // rd of sp turns the slot into addi16sp
                            if (rd == REG_SP) begin
                                res.expanded = {{3{c[12]}}, c[4:3], c[5], c[2], c[6], 4'b0000,
                                                REG_SP, F3_ADD, REG_SP, OPC_OP_IMM};
                            end else begin
                                res.expanded = {{14{c[12]}}, ci_u, rd, OPC_LUI};
                            end
                        end
                        C1_ALU: begin
                            case (c[11:10])
                                ALU_SRLI: res.expanded = {6'b0, ci_u, rdp, F3_SR, rdp, OPC_OP_IMM};
                                ALU_SRAI: res.expanded = {SRAI_MARK | {6'b0, ci_u}, rdp, F3_SR,
                                                          rdp, OPC_OP_IMM};
                                ALU_ANDI: res.expanded = {ci_s, rdp, F3_AND, rdp, OPC_OP_IMM};
                                ALU_REG: begin
                                    // bit 12 plays no part here
                                    case (c[6:5])
                                        REG_SUB: res.expanded = {F7_SUB, rs2p, rdp, F3_ADD, rdp, OPC_OP};
                                        REG_XOR: res.expanded = {F7_NONE, rs2p, rdp, F3_XOR, rdp, OPC_OP};
                                        REG_OR:  res.expanded = {F7_NONE, rs2p, rdp, F3_OR, rdp, OPC_OP};
                                        REG_AND: res.expanded = {F7_NONE, rs2p, rdp, F3_AND, rdp, OPC_OP};
                                    endcase
                                end
                            endcase
                        end
                        C1_J:    res.expanded = {c[12], jump_mid, c[12], {8{c[12]}}, REG_X0, OPC_JAL};
                        C1_BEQZ: res.expanded = {{4{c[12]}}, c[6:5], c[2], REG_X0, rdp, F3_BEQ,
                                                 c[11:10], c[4:3], c[12], OPC_BRANCH};
                        C1_BNEZ: res.expanded = {{4{c[12]}}, c[6:5], c[2], REG_X0, rdp, F3_BNE,
                                                 c[11:10], c[4:3], c[12], OPC_BRANCH};
                    endcase
                end
                default: begin
                    case (c[15:13])
                        C2_SLLI:  res.expanded = {6'b0, ci_u, rd, F3_SLL, rd, OPC_OP_IMM};
                        C2_FLDSP: res.expanded = {3'b0, c[4:2], c[12], c[6:5], 3'b0, REG_SP, F3_D,
                                                  rd, OPC_LOAD_FP};
                        C2_LWSP:  res.expanded = {4'b0, c[3:2], c[12], c[6:4], 2'b0, REG_SP, F3_W,
                                                  rd, OPC_LOAD};
                        C2_FLWSP: res.expanded = {4'b0, c[3:2], c[12], c[6:4], 2'b0, REG_SP, F3_W,
                                                  rd, OPC_LOAD_FP};
                        C2_JR_ADD: begin
                            // jr / mv with bit 12 low, ebreak / jalr / add with it high
                            if (!c[12]) begin
                                if (rs2 != REG_X0) begin
                                    res.expanded = {F7_NONE, rs2, REG_X0, F3_ADD, rd, OPC_OP};
                                end else begin
                                    res.expanded = {12'd0, rd, F3_ADD, REG_X0, OPC_JALR};
                                end
                            end else if (rs2 != REG_X0) begin
                                res.expanded = {F7_NONE, rs2, rd, F3_ADD, rd, OPC_OP};
                            end else if (rd == REG_X0) begin
                                res.expanded = {EBREAK_IMM, REG_X0, F3_PRIV, REG_X0, OPC_SYSTEM};
                            end else begin
                                res.expanded = {12'd0, rd, F3_ADD, REG_RA, OPC_JALR};
                            end
                        end
                        C2_FSDSP: begin
                            s_imm        = {3'b0, c[9:7], c[12:10], 3'b0};
                            res.expanded = {s_imm[11:5], rs2, REG_SP, F3_D, s_imm[4:0], OPC_STORE_FP};
                        end
                        C2_SWSP: begin
                            s_imm        = {4'b0, c[8:7], c[12:9], 2'b0};
                            res.expanded = {s_imm[11:5], rs2, REG_SP, F3_W, s_imm[4:0], OPC_STORE};
                        end
                        C2_FSWSP: begin
                            s_imm        = {4'b0, c[8:7], c[12:9], 2'b0};
                            res.expanded = {s_imm[11:5], rs2, REG_SP, F3_W, s_imm[4:0], OPC_STORE_FP};
                        end
                    endcase
                end
            endcase
            return res;
        endfunction

        // input transaction accepted: queue its expansion
        function void note_instruction(logic [31:0] word);
            pending_expansions.push_back(expand_word(word));
            pending_words.push_back(word);
            accepted_count++;
        endfunction

        function void log_error(string msg);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("error at %0t: %s", $time, msg);
            end
        endfunction

        // output transaction accepted: compare with the oldest expansion
        function void check_result(t_exp_result got);
            t_exp_result want;
            logic [31:0] word;
            if (pending_expansions.size() == 0) begin
                log_error($sformatf("result %h/%b/%b with nothing outstanding",
                                    got.expanded, got.was_compressed, got.illegal));
                return;
            end
            want = pending_expansions.pop_front();
            word = pending_words.pop_front();
            if (got.expanded !== want.expanded) begin
                log_error($sformatf("word %h: expanded expected %h, got %h",
                                    word, want.expanded, got.expanded));
            end
            if (got.was_compressed !== want.was_compressed) begin
                log_error($sformatf("word %h: was_compressed expected %b, got %b",
                                    word, want.was_compressed, got.was_compressed));
            end
            if (got.illegal !== want.illegal) begin
                log_error($sformatf("word %h: illegal expected %b, got %b",
                                    word, want.illegal, got.illegal));
            end
        endfunction

        function int pending();
            return pending_expansions.size();
        endfunction
    endclass

    expansion_scoreboard sb;

    rvc_instruction_expander_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_instruction    (i_instruction),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_expanded       (o_expanded),
        .o_was_compressed (o_was_compressed),
        .o_illegal        (o_illegal)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // gap length: mostly none, some short, a few long
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // random fetched word: full words, plain compressed words, and words with
    // zero or sp register fields that reach the jr/ebreak and addi16sp cases
    function automatic logic [31:0] random_instruction();
        logic [31:0] word;
        int          pick;
        word = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            word[1:0] = QUAD_FULL;
        end else begin
            word[1:0] = 2'($urandom_range(0, 2));
            if (pick < 38) begin
                case ($urandom_range(0, 2))
                    0: word[11:7] = REG_X0;
                    1: word[11:7] = REG_SP;
                    default: ;
                endcase
                if ($urandom_range(0, 1)) word[6:2] = REG_X0;
            end
        end
        return word;
    endfunction

    // offer one transaction after a random gap and hold it until accepted
    task automatic offer_instruction(input logic [31:0] word);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_instruction <= word;
        do @(posedge i_clk); while (o_stall);
        sb.note_instruction(word);
        @(negedge i_clk);
    endtask

    // receiver stalls, with one long hold-off once the run is under way
    initial begin
        int  stretch;
        bit  held_off;
        held_off = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stretch = idle_length();
            if (!held_off && sb.accepted_count >= HOLD_AFTER) begin
                held_off = 1'b1;
                stretch  = HOLD_OFF_CYCLES;
            end
            if (stretch > 0) begin
                i_stall <= 1'b1;
                repeat (stretch) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result({o_expanded, o_was_compressed, o_illegal});
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // reset, directed words, random words, drain
    initial begin
        int n;
        sb            = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_instruction = '0;
        i_stall       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        offer_instruction(32'hFFFF_FFFF);
        foreach (DIRECTED_CODES[k]) begin
            offer_instruction({16'($urandom), DIRECTED_CODES[k]});
        end
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            offer_instruction(random_instruction());
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
